// ===== hdl/gzhp_pkg.sv =====
`default_nettype none
package gzhp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned LenW    = 16;
  localparam int unsigned FlagW   = 4;

  localparam logic [ByteW-1:0] Magic0     = 8'h1F;
  localparam logic [ByteW-1:0] Magic1     = 8'h8B;
  localparam logic [ByteW-1:0] Magic1Old  = 8'h9E;
  localparam logic [ByteW-1:0] MethodDefl = 8'h08;
  localparam logic [IndexW-1:0] IdxMagic0 = 4'd0;
  localparam logic [IndexW-1:0] IdxMagic1 = 4'd1;
  localparam logic [IndexW-1:0] IdxMethod = 4'd2;
  localparam logic [IndexW-1:0] IdxFlags  = 4'd3;
  localparam logic [IndexW-1:0] IdxLast   = 4'd9;

  // flag_bits layout: FLG byte shifted right by one
  localparam int unsigned FlgHcrc    = 0;
  localparam int unsigned FlgExtra   = 1;
  localparam int unsigned FlgName    = 2;
  localparam int unsigned FlgComment = 3;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN_LO = 4'd1,
    PH_XLEN_HI = 4'd2,
    PH_XDATA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC0   = 4'd6,
    PH_HCRC1   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_HALTED  = 4'd9
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_HEADER    = 4'd0,
    ST_DONE      = 4'd1,
    ST_PAYLOAD   = 4'd2,
    ST_BADHDR    = 4'd3,
    ST_BADMETH   = 4'd4,
    ST_TRUNC_XTR = 4'd5,
    ST_TRUNC_NAM = 4'd6,
    ST_TRUNC_CMT = 4'd7,
    ST_TRUNC_CRC = 4'd8,
    ST_HALTED    = 4'd9
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic [IndexW-1:0] fixed_index;
    logic [LenW-1:0]   extra_left;
    logic [FlagW-1:0]  flag_bits;
    logic [ByteW-1:0]  length_low;
  } gzhp_state_t;

  localparam gzhp_state_t StateReset = '{
    phase:       PH_FIXED,
    fixed_index: '0,
    extra_left:  '0,
    flag_bits:   '0,
    length_low:  '0
  };

  // Status for end of input while the given section is still needed.
  function automatic status_t trunc_code(input phase_t ph);
    status_t s;
    s = ST_BADHDR;
    unique case (ph)
      PH_XLEN_LO, PH_XLEN_HI, PH_XDATA: s = ST_TRUNC_XTR;
      PH_NAME:                          s = ST_TRUNC_NAM;
      PH_COMMENT:                       s = ST_TRUNC_CMT;
      PH_HCRC0, PH_HCRC1:               s = ST_TRUNC_CRC;
      default:                          s = ST_BADHDR;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gzhp_step.sv =====
`default_nettype none
// One parse step: parser state and one byte in, next state and status out.
module gzhp_step (
  input  var gzhp_pkg::gzhp_state_t st,
  input  wire [gzhp_pkg::ByteW-1:0] byte_in,
  input  wire                       last,
  output gzhp_pkg::gzhp_state_t     st_next,
  output gzhp_pkg::status_t         status,
  output logic [gzhp_pkg::ByteW-1:0] out_byte
);
  import gzhp_pkg::*;

  // first optional section from stage on (0 extra, 1 name, 2 comment, 3 crc)
  function automatic phase_t section_from(input logic [1:0] stage,
                                          input logic [FlagW-1:0] flg);
    phase_t p;
    p = PH_PAYLOAD;
    priority if (stage == 2'd0 && flg[FlgExtra])   p = PH_XLEN_LO;
    else if (stage <= 2'd1 && flg[FlgName])        p = PH_NAME;
    else if (stage <= 2'd2 && flg[FlgComment])     p = PH_COMMENT;
    else if (flg[FlgHcrc])                         p = PH_HCRC0;
    else                                           p = PH_PAYLOAD;
    return p;
  endfunction

  status_t           cerr;      // content error, ST_HEADER if none
  phase_t            sect;      // section the byte leads into
  logic              pass;      // payload or halted: no header logic
  logic [LenW-1:0]   xlen;
  logic [LenW-1:0]   xdec;

  assign xlen = {byte_in, st.length_low};
  assign xdec = st.extra_left - LenW'(1);

  // decode
  always_comb begin
    cerr = ST_HEADER;
    sect = st.phase;
    pass = 1'b0;
    unique case (st.phase)
      PH_FIXED: begin
        if (st.fixed_index == IdxMagic0 && byte_in != Magic0) begin
          cerr = ST_BADHDR;
        end else if (st.fixed_index == IdxMagic1 && byte_in != Magic1 &&
                     byte_in != Magic1Old) begin
          cerr = ST_BADHDR;
        end else if (st.fixed_index == IdxMethod && byte_in != MethodDefl) begin
          cerr = ST_BADMETH;
        end
        if (st.fixed_index >= IdxLast) sect = section_from(2'd0, st.flag_bits);
      end
      PH_XLEN_LO: sect = PH_XLEN_HI;
      PH_XLEN_HI: sect = (xlen == '0) ? section_from(2'd1, st.flag_bits) : PH_XDATA;
      PH_XDATA:   if (xdec == '0) sect = section_from(2'd1, st.flag_bits);
      PH_NAME:    if (byte_in == '0) sect = section_from(2'd2, st.flag_bits);
      PH_COMMENT: if (byte_in == '0) sect = section_from(2'd3, st.flag_bits);
      PH_HCRC0:   sect = PH_HCRC1;
      PH_HCRC1:   sect = PH_PAYLOAD;
      default:    pass = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    st_next = st;
    if (pass) begin
      if (st.phase != PH_PAYLOAD) st_next.phase = PH_HALTED;
    end else begin
      unique case (st.phase)
        PH_FIXED: begin
          if (cerr == ST_HEADER) begin
            if (st.fixed_index == IdxFlags) st_next.flag_bits = byte_in[FlagW:1];
            st_next.fixed_index = (st.fixed_index >= IdxLast) ? '0
                                : st.fixed_index + IndexW'(1);
          end
        end
        PH_XLEN_LO: st_next.length_low = byte_in;
        PH_XLEN_HI: st_next.extra_left = xlen;
        PH_XDATA:   st_next.extra_left = xdec;
        default:    st_next = st;
      endcase
      priority if (cerr != ST_HEADER) st_next.phase = PH_HALTED;
      else if (sect == PH_PAYLOAD)    st_next.phase = PH_PAYLOAD;
      else if (last)                  st_next.phase = PH_HALTED;
      else                            st_next.phase = sect;
    end
  end

  // outputs
  always_comb begin
    out_byte = '0;
    if (pass) begin
      if (st.phase == PH_PAYLOAD) begin
        status   = ST_PAYLOAD;
        out_byte = byte_in;
      end else begin
        status = ST_HALTED;
      end
    end else begin
      priority if (cerr != ST_HEADER) status = cerr;
      else if (sect == PH_PAYLOAD)    status = ST_DONE;
      else if (last)                  status = trunc_code(sect);
      else                            status = ST_HEADER;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gzip_member_header_parser.sv =====
// gzip member header parser
//
// Input channel (in_valid/in_ready): one byte of a gzip member per
// transaction, with end_of_input marking the last byte available.
// Output channel (out_valid/out_ready): one transaction per input byte,
// carrying status and out_byte (the byte itself when status is payload,
// zero otherwise). Errors and truncation halt the parser; every later
// byte then reports halted until reset.
//
// An accepted byte goes into the input register, then into the result
// register, where out_valid rises. Throughput: one byte per cycle while
// out_ready stays high; the parse step is combinational logic between the
// two registers, and the parser state updates along with the result register.
//
// Reset (rst, synchronous): both registers empty, parser at the first
// fixed header byte, flags and extra length cleared.
// Receiver stall: the result register holds; the input register takes one
// more byte if it is empty, then in_ready drops until out_ready returns.
`default_nettype none
module gzip_member_header_parser (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [gzhp_pkg::ByteW-1:0]      in_byte,
  input  wire                            end_of_input,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [gzhp_pkg::StatusW-1:0]   status,
  output logic [gzhp_pkg::ByteW-1:0]     out_byte
);
  import gzhp_pkg::*;

  // input register
  logic             iv;
  logic [ByteW-1:0] ib;
  logic             il;

  // parser state
  gzhp_state_t      st;
  gzhp_state_t      st_next;
  status_t          step_status;
  logic [ByteW-1:0] step_byte;

  logic             advance;   // input register moves into result register

  assign advance  = iv && (!out_valid || out_ready);
  assign in_ready = !iv || advance;

  gzhp_step u_step (
    .st       (st),
    .byte_in  (ib),
    .last     (il),
    .st_next  (st_next),
    .status   (step_status),
    .out_byte (step_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_byte;
      il <= end_of_input;
    end
  end

  // state commits only when the byte's result is taken into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status   <= step_status;
      out_byte <= step_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gzhp_checker.sv =====
`default_nettype none
module gzhp_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [gzhp_pkg::StatusW-1:0]  status,
  input wire [gzhp_pkg::ByteW-1:0]    out_byte
);
  import gzhp_pkg::*;

  logic err_seen;
  logic is_err;

  assign is_err = (status >= ST_BADHDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (out_valid && out_ready && is_err) begin
      err_seen <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte))
    else $error("stalled result changed");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PAYLOAD |-> out_byte == '0)
    else $error("out_byte nonzero outside payload");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && err_seen |-> status == ST_HALTED)
    else $error("result after an error is not halted");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_HALTED)
    else $error("status code out of range");

endmodule

bind gzip_member_header_parser gzhp_checker u_gzhp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_byte  (out_byte)
);
`default_nettype wire

// ===== tb/gzip_member_header_parser_tb.sv =====
`timescale 1ns / 100ps

module gzip_member_header_parser_tb;
  import gzhp_pkg::*;

  // Cycles without any transaction on either channel before the run is
  // declared hung; well above the longest gap or stall that pick_gap draws.
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned RandomBytes = 950;

  // Optional header sections, in the order they follow the fixed part.
  localparam int unsigned StageExtra   = 0;
  localparam int unsigned StageName    = 1;
  localparam int unsigned StageComment = 2;
  localparam int unsigned StageCrc     = 3;

  // Header shapes; anything at or above FaultNone is well formed.
  localparam int unsigned FaultMagic0 = 0;
  localparam int unsigned FaultMagic1 = 1;
  localparam int unsigned FaultMethod = 2;
  localparam int unsigned FaultCut    = 3;
  localparam int unsigned FaultNone   = 4;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    bit               hold;   // wait for all results before sending
  } stream_byte_t;

  typedef struct {
    status_t          st;
    logic [ByteW-1:0] data;
  } byte_verdict_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [ByteW-1:0]   in_byte      = '0;
  logic               end_of_input = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   out_byte;

  gzip_member_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_byte     (out_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stream_byte_t  stream_q[$];      // bytes waiting to be sent
  stream_byte_t  header_q[$];      // header under construction
  byte_verdict_t verdicts_due[$];  // expected results, oldest first

  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned status_seen[16];

  // Shape of the header chosen for this run, for the summary.
  logic [ByteW-1:0] hdr_flg;
  int unsigned      hdr_xlen;
  int unsigned      hdr_fault;

  // ---------------------------------------------------------------------
  // Parser model: a private copy of the parse state, advanced once per
  // accepted input transaction.
  // ---------------------------------------------------------------------
  phase_t            p_phase = PH_FIXED;
  logic [IndexW-1:0] p_idx   = '0;
  logic [LenW-1:0]   p_left  = '0;
  logic [FlagW-1:0]  p_flags = '0;
  logic [ByteW-1:0]  p_lenlo = '0;

  // First optional section still to come at or after the given stage.
  function automatic phase_t section_after(input int unsigned stage);
    if (stage <= StageExtra && p_flags[FlgExtra]) return PH_XLEN_LO;
    if (stage <= StageName && p_flags[FlgName]) return PH_NAME;
    if (stage <= StageComment && p_flags[FlgComment]) return PH_COMMENT;
    if (stage <= StageCrc && p_flags[FlgHcrc]) return PH_HCRC0;
    return PH_PAYLOAD;
  endfunction

  // Error code when the stream ends while this section is still owed.
  function automatic status_t missing_section(input phase_t ph);
    case (ph)
      PH_XLEN_LO, PH_XLEN_HI, PH_XDATA: return ST_TRUNC_XTR;
      PH_NAME:                          return ST_TRUNC_NAM;
      PH_COMMENT:                       return ST_TRUNC_CMT;
      PH_HCRC0, PH_HCRC1:               return ST_TRUNC_CRC;
      default:                          return ST_BADHDR;
    endcase
  endfunction

  task automatic parse_byte(input logic [ByteW-1:0] b, input logic last,
                            output status_t st, output logic [ByteW-1:0] ob);
    phase_t        nxt;
    logic [LenW-1:0] len;
    bit            in_header;
    nxt       = p_phase;
    st        = ST_HEADER;
    ob        = '0;
    in_header = (p_phase < PH_PAYLOAD);
    case (p_phase)
      PH_FIXED: begin
        if (p_idx == IdxMagic0 && b != Magic0) begin
          st = ST_BADHDR;
        end else if (p_idx == IdxMagic1 && b != Magic1 && b != Magic1Old) begin
          st = ST_BADHDR;
        end else if (p_idx == IdxMethod && b != MethodDefl) begin
          st = ST_BADMETH;
        end else begin
          // FLG bit 0 (text) and the reserved top bits are dropped
          if (p_idx == IdxFlags) p_flags = b[4:1];
          if (p_idx >= IdxLast) begin
            p_idx = '0;
            nxt   = section_after(StageExtra);
          end else begin
            p_idx = p_idx + IndexW'(1);
          end
        end
      end
      PH_XLEN_LO: begin
        p_lenlo = b;
        nxt     = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        len    = {b, p_lenlo};
        p_left = len;
        // zero length skips the extra data entirely
        nxt    = (len == '0) ? section_after(StageName) : PH_XDATA;
      end
      PH_XDATA: begin
        p_left = p_left - LenW'(1);
        if (p_left == '0) nxt = section_after(StageName);
      end
      PH_NAME:    if (b == '0) nxt = section_after(StageComment);
      PH_COMMENT: if (b == '0) nxt = section_after(StageCrc);
      PH_HCRC0:   nxt = PH_HCRC1;
      PH_HCRC1:   nxt = PH_PAYLOAD;
      PH_PAYLOAD: begin
        // end of input here is plain payload, and so is all that follows
        st = ST_PAYLOAD;
        ob = b;
      end
      default: begin
        p_phase = PH_HALTED;
        st      = ST_HALTED;
      end
    endcase

    if (in_header) begin
      // a content error beats end of input on the same byte
      if (st != ST_HEADER) begin
        p_phase = PH_HALTED;
      end else if (nxt == PH_PAYLOAD) begin
        st      = ST_DONE;
        p_phase = PH_PAYLOAD;
      end else if (last) begin
        st      = missing_section(nxt);
        p_phase = PH_HALTED;
      end else begin
        p_phase = nxt;
      end
    end
    status_seen[int'(st)]++;
  endtask

  // Mostly back to back, some short gaps, a few long ones; every 300
  // transactions the first 60 see no idling at all.
  function automatic int unsigned pick_gap(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n % 300) < 60) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_hdr(input logic [ByteW-1:0] d);
    header_q.push_back('{d, 1'b0, 1'b0});
  endtask

  // ---------------------------------------------------------------------
  // Driver: sends queued bytes on the input channel. The prediction is
  // made at the edge where the input transaction is accepted.
  // ---------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk) begin : drive
    status_t          st;
    logic [ByteW-1:0] ob;
    stream_byte_t     nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte, end_of_input, st, ob);
        verdicts_due.push_back('{st, ob});
        n_sent++;
      end
      // payload stays put until the current transaction completes
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0 &&
                     !(stream_q[0].hold && verdicts_due.size() != 0)) begin
          nb = stream_q.pop_front();
          in_byte      <= nb.data;
          end_of_input <= nb.last;
          in_valid     <= 1'b1;
          send_gap = pick_gap(n_sent);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, and every output transaction checked
  // against the oldest expectation.
  // ---------------------------------------------------------------------
  int unsigned recv_stall = 0;

  always @(posedge clk) begin : observe
    byte_verdict_t v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: status %0d out_byte 0x%02h", status, out_byte);
          errors++;
        end else begin
          v = verdicts_due.pop_front();
          if (status !== v.st) begin
            $error("status mismatch: expected %0d, actual %0d", v.st, status);
            errors++;
          end
          if (out_byte !== v.data) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                   v.data, out_byte);
            errors++;
          end
          n_checked++;
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = pick_gap(n_checked);
      end
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus. Reset happens once, and errors are sticky, so a run parses
  // exactly one member header; its shape is drawn at random per seed.
  // Most runs get a well-formed header, the rest a bad magic, a bad
  // method or a stream cut short somewhere inside the header.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [ByteW-1:0] v;
    int unsigned      n;
    int unsigned      pos;

    hdr_fault = $urandom_range(0, 9);
    hdr_flg   = 8'($urandom_range(0, 255));
    for (int k = 1; k <= 4; k++) hdr_flg[k] = ($urandom_range(0, 3) != 0);
    hdr_xlen  = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300)
                                            : $urandom_range(0, 4);

    // fixed part: magic, method, flags, mtime, xfl, os
    add_hdr(Magic0);
    add_hdr($urandom_range(0, 1) ? Magic1 : Magic1Old);
    add_hdr(MethodDefl);
    add_hdr(hdr_flg);
    for (int k = 0; k < 6; k++) add_hdr(8'($urandom_range(0, 255)));

    if (hdr_flg[FlgExtra + 1]) begin
      add_hdr(hdr_xlen[7:0]);
      add_hdr(hdr_xlen[15:8]);
      for (int k = 0; k < hdr_xlen; k++) add_hdr(8'($urandom_range(0, 255)));
    end
    if (hdr_flg[FlgName + 1]) begin
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) add_hdr(8'($urandom_range(1, 255)));
      add_hdr('0);
    end
    if (hdr_flg[FlgComment + 1]) begin
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) add_hdr(8'($urandom_range(1, 255)));
      add_hdr('0);
    end
    if (hdr_flg[FlgHcrc + 1]) begin
      add_hdr(8'($urandom_range(0, 255)));
      add_hdr(8'($urandom_range(0, 255)));
    end

    case (hdr_fault)
      FaultMagic0: begin
        v = Magic0;
        while (v == Magic0) v = 8'($urandom_range(0, 255));
        header_q[0].data = v;
      end
      FaultMagic1: begin
        v = Magic1;
        while (v == Magic1 || v == Magic1Old) v = 8'($urandom_range(0, 255));
        header_q[1].data = v;
      end
      FaultMethod: begin
        v = MethodDefl;
        while (v == MethodDefl) v = 8'($urandom_range(0, 255));
        header_q[2].data = v;
      end
      FaultCut: begin
        // stream ends early, anywhere up to and including the last byte
        pos = $urandom_range(0, header_q.size() - 1);
        header_q[pos].last = 1'b1;
      end
      default: begin
        // end of input on the final header byte is not an error
        if ($urandom_range(0, 3) == 0) header_q[header_q.size() - 1].last = 1'b1;
      end
    endcase
    foreach (header_q[k]) stream_q.push_back(header_q[k]);

    // payload extremes; the first waits for the header results to drain
    stream_q.push_back('{8'h00, 1'b0, 1'b1});
    stream_q.push_back('{8'hFF, 1'b1, 1'b0});
    stream_q.push_back('{8'h55, 1'b0, 1'b0});
    stream_q.push_back('{8'hAA, 1'b1, 1'b0});
    stream_q.push_back('{Magic0, 1'b0, 1'b0});

    for (int k = 0; k < RandomBytes; k++) begin
      stream_q.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                           k == RandomBytes / 2});
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    // wait on so that a stray late result would be caught
    repeat (8) @(posedge clk);

    $display("covered one member header: FLG 0x%02h, extra length %0d, shape %0d",
             hdr_flg, hdr_xlen, hdr_fault);
    $display("checked %0d transactions: %0d header, %0d payload, %0d error or halted",
             n_checked, status_seen[ST_HEADER] + status_seen[ST_DONE],
             status_seen[ST_PAYLOAD],
             n_checked - status_seen[ST_HEADER] - status_seen[ST_DONE]
             - status_seen[ST_PAYLOAD]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
